FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the tag lexer.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that cond never holds outside reset
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

FILE: sv/xtl_pkg.sv
// ----------------------------------------------------------------------------
// XML tag lexer package
// Word types, character codes, class and error codes for the lexer.
// ----------------------------------------------------------------------------
package xtl_pkg;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_NL    = 8'h0A;

   localparam logic [2:0] CLS_NONE  = 3'd0;
   localparam logic [2:0] CLS_OPEN  = 3'd1;
   localparam logic [2:0] CLS_TNAME = 3'd2;
   localparam logic [2:0] CLS_ANAME = 3'd3;
   localparam logic [2:0] CLS_VALUE = 3'd4;

   localparam logic [1:0] ERR_NONE  = 2'd0;
   localparam logic [1:0] ERR_STRAY = 2'd1;
   localparam logic [1:0] ERR_QUOTE = 2'd2;
   localparam logic [1:0] ERR_EOF   = 2'd3;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   typedef struct packed {
      logic       cmd;
      logic [7:0] byte_value;
   } req_word_type;

   typedef struct packed {
      logic [2:0] char_class;
      logic [7:0] char_out;
      logic       attr_begins;
      logic       option_done;
      logic       tag_done;
      logic       tag_self_closing;
      logic       tag_closing;
      logic [1:0] error_code;
   } rsp_word_type;

   typedef struct packed {
      logic       inside_tag;
      logic       inside_name;
      logic       inside_attribute;
      logic       inside_value;
      logic       inside_quotes;
      logic       name_started;
      logic       value_started;
      logic       self_closing_flag;
      logic       closing_flag;
      logic [1:0] sticky_error;
   } lex_state_type;

   localparam lex_state_type LEX_STATE_RESET = '0;

endpackage

FILE: sv/xtl_step.sv
// ----------------------------------------------------------------------------
// XML tag lexer step
// Next lexer state and result word for one input word.
// ----------------------------------------------------------------------------
module xtl_step (
   input  xtl_pkg::lex_state_type cur_state,
   input  xtl_pkg::req_word_type  req_word,
   output xtl_pkg::lex_state_type next_state,
   output xtl_pkg::rsp_word_type  rsp_word
);

   logic [7:0]           c;
   logic [2:0]           cls;
   logic                 attr_b;
   logic                 opt_d;
   logic                 done;
   xtl_pkg::lex_state_type s;

   assign c = (req_word.cmd == xtl_pkg::CMD_END) ? 8'h00 : req_word.byte_value;

   always_comb begin
      s      = cur_state;
      cls    = xtl_pkg::CLS_NONE;
      attr_b = 1'b0;
      opt_d  = 1'b0;
      done   = 1'b0;
      if (cur_state.sticky_error == xtl_pkg::ERR_NONE) begin
         if (req_word.cmd == xtl_pkg::CMD_END) begin
            if (cur_state.inside_tag) begin
               s.sticky_error = xtl_pkg::ERR_EOF;
            end
         end else if (!cur_state.inside_tag) begin
            if (c == xtl_pkg::CH_LT) begin
               s            = xtl_pkg::LEX_STATE_RESET;
               s.inside_tag = 1'b1;
               cls          = xtl_pkg::CLS_OPEN;
            end else if (!(c inside {xtl_pkg::CH_SP, xtl_pkg::CH_NL})) begin
               s.sticky_error = xtl_pkg::ERR_STRAY;
            end
         end else if (cur_state.inside_name) begin
            case (c)
               xtl_pkg::CH_SLASH: begin
                  s.inside_name       = 1'b0;
                  s.self_closing_flag = 1'b1;
               end
               xtl_pkg::CH_SP: begin
                  s.inside_name = 1'b0;
               end
               xtl_pkg::CH_GT: begin
                  s.inside_name = 1'b0;
                  s.inside_tag  = 1'b0;
                  done          = 1'b1;
               end
               default: begin
                  s.name_started = 1'b1;
                  cls            = xtl_pkg::CLS_TNAME;
               end
            endcase
         end else if (cur_state.inside_attribute) begin
            if (cur_state.inside_value) begin
               if (cur_state.inside_quotes) begin
                  if (c == xtl_pkg::CH_QUOTE) begin
                     s.inside_quotes    = 1'b0;
                     s.inside_value     = 1'b0;
                     s.inside_attribute = 1'b0;
                  end else begin
                     s.value_started = 1'b1;
                     cls             = xtl_pkg::CLS_VALUE;
                  end
               end else begin
                  case (c)
                     xtl_pkg::CH_SLASH: begin
                        s.inside_attribute  = 1'b0;
                        s.inside_value      = 1'b0;
                        s.self_closing_flag = 1'b1;
                     end
                     xtl_pkg::CH_QUOTE: begin
                        if (!cur_state.value_started) begin
                           s.inside_quotes = 1'b1;
                        end else begin
                           s.sticky_error = xtl_pkg::ERR_QUOTE;
                        end
                     end
                     xtl_pkg::CH_SP: begin
                        s.inside_attribute = 1'b0;
                        s.inside_value     = 1'b0;
                     end
                     xtl_pkg::CH_GT: begin
                        s.inside_attribute = 1'b0;
                        s.inside_value     = 1'b0;
                        s.inside_tag       = 1'b0;
                        done               = 1'b1;
                     end
                     default: begin
                        s.value_started = 1'b1;
                        cls             = xtl_pkg::CLS_VALUE;
                     end
                  endcase
               end
            end else begin
               case (c)
                  xtl_pkg::CH_SLASH: begin
                     s.self_closing_flag = 1'b1;
                     s.inside_attribute  = 1'b0;
                     opt_d               = 1'b1;
                  end
                  xtl_pkg::CH_GT: begin
                     opt_d              = 1'b1;
                     s.inside_attribute = 1'b0;
                     s.inside_tag       = 1'b0;
                     done               = 1'b1;
                  end
                  xtl_pkg::CH_EQ: begin
                     attr_b          = 1'b1;
                     s.inside_value  = 1'b1;
                     s.value_started = 1'b0;
                  end
                  default: begin
                     cls = xtl_pkg::CLS_ANAME;
                  end
               endcase
            end
         end else begin
            case (c)
               xtl_pkg::CH_SLASH: begin
                  if (!cur_state.name_started) begin
                     s.closing_flag = 1'b1;
                  end else begin
                     s.self_closing_flag = 1'b1;
                  end
               end
               xtl_pkg::CH_GT: begin
                  s.inside_tag = 1'b0;
                  done         = 1'b1;
               end
               xtl_pkg::CH_SP: begin
               end
               default: begin
                  if (!cur_state.name_started) begin
                     s.inside_name  = 1'b1;
                     s.name_started = 1'b1;
                     cls            = xtl_pkg::CLS_TNAME;
                  end else begin
                     s.inside_attribute = 1'b1;
                     s.inside_value     = 1'b0;
                     s.value_started    = 1'b0;
                     cls                = xtl_pkg::CLS_ANAME;
                  end
               end
            endcase
         end
      end
   end

   assign next_state                = s;
   assign rsp_word.char_class       = cls;
   assign rsp_word.char_out         = c;
   assign rsp_word.attr_begins      = attr_b;
   assign rsp_word.option_done      = opt_d;
   assign rsp_word.tag_done         = done;
   assign rsp_word.tag_self_closing = done & s.self_closing_flag;
   assign rsp_word.tag_closing      = done & s.closing_flag;
   assign rsp_word.error_code       = s.sticky_error;

endmodule

FILE: sv/xml_tag_lexer_core.sv
// An accepted word is held in the input register; its result is then registered
// in the result register and presented on rsp_.
// Throughput: one byte per cycle while the result side does not stall; the lexer
// state loop closes in the step logic. The input and result registers each hold
// one word, so a stalled result still lets one more byte in.
// Reset: synchronous; clears the lexer state and empties both registers.
// ----------------------------------------------------------------------------
// XML tag lexer core
// Byte-serial tag tokenizer with an input register and a result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xml_tag_lexer_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  xtl_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output xtl_pkg::rsp_word_type rsp_word
);

   logic                   in_valid_ff;
   xtl_pkg::req_word_type  in_word_ff;
   logic                   out_valid_ff;
   xtl_pkg::rsp_word_type  out_word_ff;
   xtl_pkg::lex_state_type state_ff;
   xtl_pkg::lex_state_type state_in;
   xtl_pkg::rsp_word_type  out_word_in;
   logic                   advance;

   xtl_step u_step (
      .cur_state  (state_ff),
      .req_word   (in_word_ff),
      .next_state (state_in),
      .rsp_word   (out_word_in)
   );

   assign advance   = in_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall = in_valid_ff & ~advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= xtl_pkg::LEX_STATE_RESET;
      end else begin
         if (req_valid && !req_stall) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         out_word_ff <= out_word_in;
      end
   end

   `ASSERT_CLK(a_error_freezes_state, clock, reset,
      state_ff.sticky_error != xtl_pkg::ERR_NONE |=> $stable(state_ff), "state moved after error")
   `ASSERT_CLK(a_error_no_class, clock, reset,
      rsp_valid && rsp_word.error_code != xtl_pkg::ERR_NONE |->
      rsp_word.char_class == xtl_pkg::CLS_NONE, "class reported with error")
   `ASSERT_NEVER(a_stall_when_empty, clock, reset,
      req_stall && !in_valid_ff, "input stalled with empty register")
   `ASSERT_CLK(a_flags_need_done, clock, reset,
      rsp_valid && (rsp_word.tag_self_closing || rsp_word.tag_closing) |->
      rsp_word.tag_done, "tag flags without tag done")

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XML tag lexer core testbench
// Streams directed and random tag text through the lexer with random gaps on
// the byte side and random stalls on the result side. Each accepted byte is run
// through a local lexer model and the resulting word is compared field by field
// with what the core returns. The run closes with at most one sticky error chosen
// at random, followed by bytes that must leave the frozen state untouched.
// ----------------------------------------------------------------------------
module testbench;

   localparam int ITEM_COUNT  = 790;
   localparam int CYCLE_LIMIT = 300000;
   localparam int DRAIN_WAIT  = 8;

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   xtl_pkg::req_word_type req_word  = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   xtl_pkg::rsp_word_type rsp_word;

   xtl_pkg::req_word_type  byte_queue[$];
   xtl_pkg::rsp_word_type  predicted_tokens[$];
   xtl_pkg::lex_state_type plan_state   = '0;
   xtl_pkg::lex_state_type lexer_state  = '0;
   bit            allow_errors = 1'b0;
   bit            req_quiet    = 1'b0;
   bit            rsp_quiet    = 1'b0;
   int            gap_cnt      = 0;
   int            stall_cnt    = 0;
   int            cycle_count  = 0;
   int            mismatch_count = 0;
   int            words_in     = 0;
   int            ends_in      = 0;
   int            checked      = 0;
   int            tags_done    = 0;
   logic [1:0]    last_error   = xtl_pkg::ERR_NONE;

   xml_tag_lexer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   function automatic xtl_pkg::rsp_word_type lex_byte(input xtl_pkg::lex_state_type cur,
                                                      input xtl_pkg::req_word_type w,
                                                      output xtl_pkg::lex_state_type nxt);
      xtl_pkg::lex_state_type s;
      xtl_pkg::rsp_word_type  r;
      logic [7:0]    c;
      s = cur;
      r = '0;
      c = (w.cmd == xtl_pkg::CMD_END) ? 8'h00 : w.byte_value;
      r.char_class = xtl_pkg::CLS_NONE;
      if (s.sticky_error == xtl_pkg::ERR_NONE) begin
         if (w.cmd == xtl_pkg::CMD_END) begin
            if (s.inside_tag) s.sticky_error = xtl_pkg::ERR_EOF;
         end else if (!s.inside_tag) begin
            if (c == xtl_pkg::CH_LT) begin
               s = '0;
               s.inside_tag = 1'b1;
               r.char_class = xtl_pkg::CLS_OPEN;
            end else if (c != xtl_pkg::CH_SP && c != xtl_pkg::CH_NL) begin
               s.sticky_error = xtl_pkg::ERR_STRAY;
            end
         end else if (s.inside_name) begin
            if (c == xtl_pkg::CH_SLASH) begin
               s.inside_name = 1'b0;
               s.self_closing_flag = 1'b1;
            end else if (c == xtl_pkg::CH_SP) begin
               s.inside_name = 1'b0;
            end else if (c == xtl_pkg::CH_GT) begin
               s.inside_name = 1'b0;
               s.inside_tag = 1'b0;
               r.tag_done = 1'b1;
            end else begin
               s.name_started = 1'b1;
               r.char_class = xtl_pkg::CLS_TNAME;
            end
         end else if (s.inside_attribute) begin
            if (s.inside_value) begin
               if (s.inside_quotes) begin
                  if (c == xtl_pkg::CH_QUOTE) begin
                     s.inside_quotes = 1'b0;
                     s.inside_value = 1'b0;
                     s.inside_attribute = 1'b0;
                  end else begin
                     s.value_started = 1'b1;
                     r.char_class = xtl_pkg::CLS_VALUE;
                  end
               end else if (c == xtl_pkg::CH_SLASH) begin
                  s.inside_attribute = 1'b0;
                  s.inside_value = 1'b0;
                  s.self_closing_flag = 1'b1;
               end else if (c == xtl_pkg::CH_QUOTE) begin
                  if (!s.value_started) s.inside_quotes = 1'b1;
                  else s.sticky_error = xtl_pkg::ERR_QUOTE;
               end else if (c == xtl_pkg::CH_SP) begin
                  s.inside_attribute = 1'b0;
                  s.inside_value = 1'b0;
               end else if (c == xtl_pkg::CH_GT) begin
                  s.inside_attribute = 1'b0;
                  s.inside_value = 1'b0;
                  s.inside_tag = 1'b0;
                  r.tag_done = 1'b1;
               end else begin
                  s.value_started = 1'b1;
                  r.char_class = xtl_pkg::CLS_VALUE;
               end
            end else if (c == xtl_pkg::CH_SLASH) begin
               s.self_closing_flag = 1'b1;
               s.inside_attribute = 1'b0;
               r.option_done = 1'b1;
            end else if (c == xtl_pkg::CH_GT) begin
               s.inside_attribute = 1'b0;
               s.inside_tag = 1'b0;
               r.option_done = 1'b1;
               r.tag_done = 1'b1;
            end else if (c == xtl_pkg::CH_EQ) begin
               s.inside_value = 1'b1;
               s.value_started = 1'b0;
               r.attr_begins = 1'b1;
            end else begin
               r.char_class = xtl_pkg::CLS_ANAME;
            end
         end else if (c == xtl_pkg::CH_SLASH) begin
            if (!s.name_started) s.closing_flag = 1'b1;
            else s.self_closing_flag = 1'b1;
         end else if (c == xtl_pkg::CH_GT) begin
            s.inside_tag = 1'b0;
            r.tag_done = 1'b1;
         end else if (c != xtl_pkg::CH_SP) begin
            if (!s.name_started) begin
               s.inside_name = 1'b1;
               s.name_started = 1'b1;
               r.char_class = xtl_pkg::CLS_TNAME;
            end else begin
               s.inside_attribute = 1'b1;
               s.inside_value = 1'b0;
               s.value_started = 1'b0;
               r.char_class = xtl_pkg::CLS_ANAME;
            end
         end
      end
      r.char_out = c;
      r.tag_self_closing = r.tag_done & s.self_closing_flag;
      r.tag_closing = r.tag_done & s.closing_flag;
      r.error_code = s.sticky_error;
      nxt = s;
      return r;
   endfunction

   function automatic int pick_pause(inout bit quiet);
      int r;
      if ($urandom_range(0, 199) == 0) quiet = !quiet;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // draw a random byte that differs from the four given codes
   function automatic logic [7:0] pick_byte(input logic [7:0] a, input logic [7:0] b,
                                            input logic [7:0] c, input logic [7:0] d);
      logic [7:0] v;
      do v = 8'($urandom); while (v == a || v == b || v == c || v == d);
      return v;
   endfunction

   function automatic logic [7:0] special_byte();
      case ($urandom_range(0, 6))
         0:       return xtl_pkg::CH_LT;
         1:       return xtl_pkg::CH_GT;
         2:       return xtl_pkg::CH_SLASH;
         3:       return xtl_pkg::CH_EQ;
         4:       return xtl_pkg::CH_SP;
         5:       return xtl_pkg::CH_QUOTE;
         default: return xtl_pkg::CH_NL;
      endcase
   endfunction

   // queue one word; unless errors are allowed, a word that would raise an error turns into a space
   task automatic put(input logic cmd, input logic [7:0] value);
      xtl_pkg::req_word_type  w;
      xtl_pkg::lex_state_type nxt;
      xtl_pkg::rsp_word_type  r;
      w.cmd = cmd;
      w.byte_value = value;
      r = lex_byte(plan_state, w, nxt);
      if (r.error_code != xtl_pkg::ERR_NONE && !allow_errors) begin
         w.cmd = xtl_pkg::CMD_BYTE;
         w.byte_value = xtl_pkg::CH_SP;
         r = lex_byte(plan_state, w, nxt);
      end
      plan_state = nxt;
      byte_queue = {byte_queue, w};
   endtask

   task automatic put_text(input string text);
      for (int i = 0; i < text.len(); i++) put(xtl_pkg::CMD_BYTE, text[i]);
   endtask

   task automatic close_tag();
      if (plan_state.inside_quotes) put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_QUOTE);
      if (plan_state.inside_tag) put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_GT);
   endtask

   task automatic compare_field(input string field, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Mismatch on result %0d, %s: expected 0x%0h, got 0x%0h",
                     checked, field, want, got);
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results pending",
                  cycle_count, predicted_tokens.size());
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin : driver
      xtl_pkg::rsp_word_type  token;
      xtl_pkg::lex_state_type next_state;
      if (reset) begin
         req_valid <= 1'b0;
         gap_cnt = 0;
      end else begin
         if (req_valid && !req_stall) begin
            token = lex_byte(lexer_state, req_word, next_state);
            lexer_state = next_state;
            predicted_tokens = {predicted_tokens, token};
            words_in++;
            if (req_word.cmd == xtl_pkg::CMD_END) ends_in++;
         end
         if (!req_valid || !req_stall) begin
            if (gap_cnt > 0) begin
               req_valid <= 1'b0;
               gap_cnt--;
            end else if (byte_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_word <= byte_queue.pop_front();
               gap_cnt = pick_pause(req_quiet);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      xtl_pkg::rsp_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_cnt = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_tokens.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Unexpected result 0x%0h with nothing predicted", rsp_word);
            end else begin
               want = predicted_tokens.pop_front();
               compare_field("char_class", 8'(rsp_word.char_class), 8'(want.char_class));
               compare_field("char_out", rsp_word.char_out, want.char_out);
               compare_field("attr_begins", 8'(rsp_word.attr_begins),
                             8'(want.attr_begins));
               compare_field("option_done", 8'(rsp_word.option_done),
                             8'(want.option_done));
               compare_field("tag_done", 8'(rsp_word.tag_done), 8'(want.tag_done));
               compare_field("tag_self_closing", 8'(rsp_word.tag_self_closing),
                             8'(want.tag_self_closing));
               compare_field("tag_closing", 8'(rsp_word.tag_closing),
                             8'(want.tag_closing));
               compare_field("error_code", 8'(rsp_word.error_code), 8'(want.error_code));
               checked++;
               if (want.tag_done) tags_done++;
               last_error = want.error_code;
            end
         end
         if (stall_cnt > 0) begin
            rsp_stall <= 1'b1;
            stall_cnt--;
         end else begin
            rsp_stall <= 1'b0;
            stall_cnt = pick_pause(rsp_quiet);
         end
      end
   end

   initial begin : stimulus
      logic [1:0] err_pick;
      int         n_attr;
      put(xtl_pkg::CMD_END, 8'hFF);
      put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_SP);
      put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_NL);
      put_text("<t k=\"v\"o p/>");
      put_text("</x q>");
      put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_LT);
      put(xtl_pkg::CMD_BYTE, 8'hFF);
      put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_SP);
      put(xtl_pkg::CMD_BYTE, 8'h00);
      put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_EQ);
      put(xtl_pkg::CMD_BYTE, 8'h80);
      put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_GT);

      while (byte_queue.size() < ITEM_COUNT) begin
         if ($urandom_range(0, 99) < 80) begin
            put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_LT);
            if ($urandom_range(0, 3) == 0) put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_SLASH);
            repeat ($urandom_range(0, 5))
               put(xtl_pkg::CMD_BYTE, pick_byte(xtl_pkg::CH_SLASH, xtl_pkg::CH_GT,
                                                xtl_pkg::CH_SP, xtl_pkg::CH_EQ));
            n_attr = $urandom_range(0, 3);
            for (int i = 0; i < n_attr; i++) begin
               repeat ($urandom_range(1, 2)) put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_SP);
               repeat ($urandom_range(1, 4))
                  put(xtl_pkg::CMD_BYTE, pick_byte(xtl_pkg::CH_SLASH, xtl_pkg::CH_GT,
                                                   xtl_pkg::CH_SP, xtl_pkg::CH_EQ));
               case ($urandom_range(0, 4))
                  0: ;
                  1: begin
                     put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_EQ);
                     repeat ($urandom_range(0, 4))
                        put(xtl_pkg::CMD_BYTE, pick_byte(xtl_pkg::CH_SLASH, xtl_pkg::CH_GT,
                                                         xtl_pkg::CH_SP, xtl_pkg::CH_QUOTE));
                  end
                  2, 3: begin
                     put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_EQ);
                     put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_QUOTE);
                     repeat ($urandom_range(0, 5))
                        put(xtl_pkg::CMD_BYTE, pick_byte(xtl_pkg::CH_QUOTE, xtl_pkg::CH_QUOTE,
                                                         xtl_pkg::CH_QUOTE, xtl_pkg::CH_QUOTE));
                     put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_QUOTE);
                  end
                  default: repeat ($urandom_range(1, 3))
                     put(xtl_pkg::CMD_BYTE, special_byte());
               endcase
            end
            if ($urandom_range(0, 2) == 0) put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_SLASH);
            put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_GT);
            close_tag();
         end else begin
            case ($urandom_range(0, 3))
               0: put(xtl_pkg::CMD_BYTE,
                      ($urandom_range(0, 1) == 0) ? xtl_pkg::CH_SP : xtl_pkg::CH_NL);
               1: put(xtl_pkg::CMD_END, 8'($urandom));
               2: begin
                  put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_LT);
                  repeat ($urandom_range(1, 6)) put(xtl_pkg::CMD_BYTE, 8'($urandom));
                  close_tag();
               end
               default: begin
                  put(xtl_pkg::CMD_BYTE, xtl_pkg::CH_LT);
                  repeat ($urandom_range(1, 6)) put(xtl_pkg::CMD_BYTE, special_byte());
                  close_tag();
               end
            endcase
         end
      end
      close_tag();

      // finish with at most one sticky error, then bytes that must find the state frozen
      allow_errors = 1'b1;
      err_pick = 2'($urandom_range(0, 3));
      case (err_pick)
         xtl_pkg::ERR_STRAY: put(xtl_pkg::CMD_BYTE, pick_byte(xtl_pkg::CH_LT, xtl_pkg::CH_SP,
                                                               xtl_pkg::CH_NL, xtl_pkg::CH_NL));
         xtl_pkg::ERR_QUOTE: put_text("<a b=v\"");
         xtl_pkg::ERR_EOF: begin
            put_text("<a");
            put(xtl_pkg::CMD_END, 8'($urandom));
         end
         default: ;
      endcase
      repeat (12) put(1'($urandom_range(0, 1)), 8'($urandom));

      while (byte_queue.size() != 0 || req_valid || predicted_tokens.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Lexed %0d words (%0d end markers) over %0d cycles", words_in, ends_in,
               cycle_count);
      $display("Checked %0d results, %0d tags completed, final error code %0d",
               checked, tags_done, last_error);
      if (mismatch_count == 0 && predicted_tokens.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
